// ----- rtl/core/sddmm_backward_accumulate_assert.svh -----
// assertion macros shared by the checker of the gradient accumulator
`ifndef SDDMM_BACKWARD_ACCUMULATE_ASSERT_SVH
`define SDDMM_BACKWARD_ACCUMULATE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SDBA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdba assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define SDBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdba assertion failed");

`endif

// ----- rtl/core/sdba_pkg.sv -----
// types and codes shared by the gradient accumulator modules
`default_nettype none

package sdba_pkg;

    // input item codes
    localparam logic [2:0] FUNC_LOAD1  = 3'd0;
    localparam logic [2:0] FUNC_LOAD2  = 3'd1;
    localparam logic [2:0] FUNC_UPDATE = 3'd2;
    localparam logic [2:0] FUNC_READ1  = 3'd3;
    localparam logic [2:0] FUNC_READ2  = 3'd4;
    localparam logic [2:0] FUNC_CLEAR  = 3'd5;

    // classified operations passed to the back end
    localparam logic [2:0] OP_NONE      = 3'd0;
    localparam logic [2:0] OP_LOAD1     = 3'd1;
    localparam logic [2:0] OP_LOAD2     = 3'd2;
    localparam logic [2:0] OP_UPDATE    = 3'd3;
    localparam logic [2:0] OP_READ1     = 3'd4;
    localparam logic [2:0] OP_READ2     = 3'd5;
    localparam logic [2:0] OP_READ_ZERO = 3'd6;
    localparam logic [2:0] OP_CLEAR     = 3'd7;

    // configuration register indexes
    localparam logic CFG_FEAT_LEN = 1'b0;

    localparam logic [4:0] FEAT_LEN_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]         func;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [3:0]         feature;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] grad_value;
        logic               saturated;
    } rsp_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [3:0]         feature;
        logic signed [31:0] value;
    } qent_t;

    typedef struct packed {
        logic init_busy;
        logic pop;
    } back_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/sdba_front.sv -----
// front end: accepts beats, classifies them and queues them for the back end
`default_nettype none

module sdba_front #(
    parameter int ROWS         = 64,
    parameter int COLS         = 64,
    parameter int MAX_FEATURES = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cmd_valid,
    output logic                   cmd_stall,
    input  sdba_pkg::cmd_t         cmd,
    input  sdba_pkg::back_status_t status,
    output logic                   q_valid,
    output sdba_pkg::qent_t        q_ent
);

    sdba_pkg::qent_t q_reg [2];
    logic            wr_reg, wr_next;
    logic            rd_reg, rd_next;
    logic [1:0]      count_reg, count_next;
    logic            row_ok, col_ok, feat_ok;
    logic [2:0]      op;
    logic            push;

    assign row_ok  = 32'(cmd.row) < ROWS;
    assign col_ok  = 32'(cmd.col) < COLS;
    assign feat_ok = 32'(cmd.feature) < MAX_FEATURES;

    always_comb
    begin
        unique case (cmd.func)
            sdba_pkg::FUNC_LOAD1:  op = (row_ok && feat_ok) ? sdba_pkg::OP_LOAD1 : sdba_pkg::OP_NONE;
            sdba_pkg::FUNC_LOAD2:  op = (col_ok && feat_ok) ? sdba_pkg::OP_LOAD2 : sdba_pkg::OP_NONE;
            sdba_pkg::FUNC_UPDATE: op = (row_ok && col_ok) ? sdba_pkg::OP_UPDATE : sdba_pkg::OP_NONE;
            sdba_pkg::FUNC_READ1:
                op = (row_ok && feat_ok) ? sdba_pkg::OP_READ1 : sdba_pkg::OP_READ_ZERO;
            sdba_pkg::FUNC_READ2:
                op = (col_ok && feat_ok) ? sdba_pkg::OP_READ2 : sdba_pkg::OP_READ_ZERO;
            sdba_pkg::FUNC_CLEAR:  op = sdba_pkg::OP_CLEAR;
            default:               op = sdba_pkg::OP_NONE;
        endcase
    end

    assign cmd_stall = (count_reg == 2'd2) || status.init_busy;
    // ignored beats are dropped here and never reach the queue
    assign push      = cmd_valid && !cmd_stall && (op != sdba_pkg::OP_NONE);
    assign q_valid   = count_reg != 2'd0;
    assign q_ent     = q_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? !wr_reg : wr_reg;
        rd_next    = status.pop ? !rd_reg : rd_reg;
        count_next = count_reg + 2'(push) - 2'(status.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= '{op: op, row: cmd.row, col: cmd.col,
                               feature: cmd.feature, value: cmd.value};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sdba_back.sv -----
// back end: factor and gradient memories, multiply-accumulate pipeline, result register
`default_nettype none

module sdba_back #(
    parameter int ROWS         = 64,
    parameter int COLS         = 64,
    parameter int MAX_FEATURES = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    q_valid,
    input  sdba_pkg::qent_t        q_ent,
    output sdba_pkg::back_status_t status,
    input  wire  [4:0]             feat_len,
    output logic                   rsp_valid,
    input  wire                    rsp_stall,
    output sdba_pkg::rsp_t         rsp
);

    localparam int D1   = ROWS * MAX_FEATURES;
    localparam int D2   = COLS * MAX_FEATURES;
    localparam int DMAX = (D1 > D2) ? D1 : D2;
    localparam int A1   = (D1 > 1) ? $clog2(D1) : 1;
    localparam int A2   = (D2 > 1) ? $clog2(D2) : 1;
    localparam int SW   = $clog2(DMAX + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_UPD   = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [31:0] f1_mem [D1];
    logic [31:0] f2_mem [D2];
    logic [31:0] g1_mem [D1];
    logic [31:0] g2_mem [D2];

    logic [1:0]      state_reg, state_next;
    sdba_pkg::qent_t ent_reg;
    logic [4:0]      l_reg, l_next;
    logic [4:0]      n_reg;
    logic [SW-1:0]   sweep_reg, sweep_next;
    logic            init_reg, init_next;
    logic            sat_reg, sat_next;
    logic            v1_reg, v2_reg;
    logic            rdv_reg, rdsel_reg;
    logic            out_valid_reg, out_valid_next;
    sdba_pkg::rsp_t  out_reg;

    logic signed [31:0] f1_q, f2_q, g1_q, g2_q;
    logic [A1-1:0]      a1_reg, a2_reg;
    logic [A2-1:0]      b1_reg, b2_reg;
    logic signed [47:0] prod1_reg, prod2_reg;
    logic signed [31:0] acc1_reg, acc2_reg;

    logic               idle_ok, pop, is_read;
    logic [4:0]         n_w;
    logic [A1-1:0]      ra1;
    logic [A2-1:0]      ra2;
    logic [5:0]         rrow, rcol;
    logic [4:0]         ridx;
    logic signed [63:0] mul1, mul2;
    logic signed [48:0] sum1, sum2;
    logic signed [31:0] res1, res2;
    logic               s1, s2;
    logic               g1_we, g2_we;
    logic [A1-1:0]      g1_wa;
    logic [A2-1:0]      g2_wa;
    logic [31:0]        g1_wd, g2_wd;

    assign n_w = (32'(feat_len) > MAX_FEATURES) ? 5'(MAX_FEATURES) : feat_len;

    assign is_read = (q_ent.op == sdba_pkg::OP_READ1) || (q_ent.op == sdba_pkg::OP_READ2)
                  || (q_ent.op == sdba_pkg::OP_READ_ZERO);
    // a new item starts only once the previous one has left the pipeline
    assign idle_ok = (state_reg == ST_IDLE) && !v1_reg && !v2_reg && !rdv_reg;
    assign pop     = idle_ok && q_valid && (!is_read || !out_valid_reg);

    assign status.pop       = pop;
    assign status.init_busy = init_reg;

    // read addresses: the running update, or the queued item's element
    always_comb
    begin
        if (state_reg == ST_UPD)
        begin
            rrow = ent_reg.row;
            rcol = ent_reg.col;
            ridx = l_reg;
        end
        else
        begin
            rrow = q_ent.row;
            rcol = q_ent.col;
            ridx = 5'(q_ent.feature);
        end
        ra1 = A1'(int'(rrow) * MAX_FEATURES + int'(ridx));
        ra2 = A2'(int'(rcol) * MAX_FEATURES + int'(ridx));
    end

    // accumulate stage: add the truncated product and clamp to 32 bits; also forms the products
    always_comb
    begin
        sum1 = {{17{acc1_reg[31]}}, acc1_reg} + {prod1_reg[47], prod1_reg};
        sum2 = {{17{acc2_reg[31]}}, acc2_reg} + {prod2_reg[47], prod2_reg};
        s1   = (sum1[48:31] != {18{1'b0}}) && (sum1[48:31] != {18{1'b1}});
        s2   = (sum2[48:31] != {18{1'b0}}) && (sum2[48:31] != {18{1'b1}});
        res1 = s1 ? (sum1[48] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum1[31:0];
        res2 = s2 ? (sum2[48] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum2[31:0];
        mul1 = ent_reg.value * f2_q;
        mul2 = ent_reg.value * f1_q;
    end

    // gradient write port: clearing sweep or end of the pipeline
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            g1_we = sweep_reg < SW'(D1);
            g2_we = sweep_reg < SW'(D2);
            g1_wa = sweep_reg[A1-1:0];
            g2_wa = sweep_reg[A2-1:0];
            g1_wd = '0;
            g2_wd = '0;
        end
        else
        begin
            g1_we = v2_reg;
            g2_we = v2_reg;
            g1_wa = a2_reg;
            g2_wa = b2_reg;
            g1_wd = res1;
            g2_wd = res2;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        l_next         = l_reg;
        sweep_next     = sweep_reg;
        init_next      = init_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        if (v2_reg && (s1 || s2))
        begin
            sat_next = 1'b1;
        end
        if (rdv_reg)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    case (q_ent.op)
                        sdba_pkg::OP_UPDATE:
                        begin
                            l_next = 5'd0;
                            if (n_w != 5'd0)
                            begin
                                state_next = ST_UPD;
                            end
                        end
                        sdba_pkg::OP_READ_ZERO: out_valid_next = 1'b1;
                        sdba_pkg::OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                            sweep_next = '0;
                            sat_next   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_UPD:
            begin
                l_next = l_reg + 5'd1;
                if (l_reg == n_reg - 5'd1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + SW'(1);
                if (sweep_reg == SW'(DMAX - 1))
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            l_reg         <= 5'd0;
            sweep_reg     <= '0;
            init_reg      <= 1'b1;
            sat_reg       <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            l_reg         <= l_next;
            sweep_reg     <= sweep_next;
            init_reg      <= init_next;
            sat_reg       <= sat_next;
            v1_reg        <= state_reg == ST_UPD;
            v2_reg        <= v1_reg;
            rdv_reg       <= pop && ((q_ent.op == sdba_pkg::OP_READ1)
                                  || (q_ent.op == sdba_pkg::OP_READ2));
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= q_ent;
            n_reg   <= n_w;
        end
        if (pop)
        begin
            rdsel_reg <= q_ent.op == sdba_pkg::OP_READ2;
        end
        a1_reg    <= ra1;
        b1_reg    <= ra2;
        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        prod1_reg <= mul1[63:16];
        prod2_reg <= mul2[63:16];
        acc1_reg  <= g1_q;
        acc2_reg  <= g2_q;
        if (rdv_reg)
        begin
            out_reg <= '{grad_value: rdsel_reg ? g2_q : g1_q, saturated: sat_reg};
        end
        else if (pop && (q_ent.op == sdba_pkg::OP_READ_ZERO))
        begin
            out_reg <= '{grad_value: 32'sd0, saturated: sat_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        f1_q <= f1_mem[ra1];
        f2_q <= f2_mem[ra2];
        g1_q <= g1_mem[ra1];
        g2_q <= g2_mem[ra2];
        if (pop && (q_ent.op == sdba_pkg::OP_LOAD1))
        begin
            f1_mem[ra1] <= q_ent.value;
        end
        if (pop && (q_ent.op == sdba_pkg::OP_LOAD2))
        begin
            f2_mem[ra2] <= q_ent.value;
        end
        if (g1_we)
        begin
            g1_mem[g1_wa] <= g1_wd;
        end
        if (g2_we)
        begin
            g2_mem[g2_wa] <= g2_wd;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sddmm_backward_accumulate.sv -----
// sparse-dense backward gradient accumulator, top level with configuration port
//
// cmd channel (cmd_valid/cmd_stall/cmd) takes one beat per item: factor loads,
// a nonzero update, element reads of either gradient and a clear of both.
// rsp channel (rsp_valid/rsp_stall/rsp) returns one beat for each read item.
// a front end classifies beats into a two-entry queue; the back end runs them
// in order. a load writes its factor memory as it leaves the queue. an update
// issues feat_len features (at most MAX_FEATURES) to the multiply-accumulate
// pipeline, one multiply and one accumulate per gradient per cycle, and the next
// item waits for it to drain. a read's value (zero out of range) comes from the
// gradient memory into the result register. a clear sweeps the gradient memories
// one entry a cycle over max(ROWS,COLS)*MAX_FEATURES entries (1024 by default).
// after reset the same sweep runs with cmd_stall high; feat_len resets to 16.
// while rsp_stall holds, the result stays in its register; further reads wait
// but loads and updates go on.
// feat_len is written through the APB port at byte address 0.
`default_nettype none

module sddmm_backward_accumulate #(
    parameter int ROWS         = 64,
    parameter int COLS         = 64,
    parameter int MAX_FEATURES = 16
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             cmd_valid,
    output logic            cmd_stall,
    input  sdba_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  wire             rsp_stall,
    output sdba_pkg::rsp_t  rsp,
    input  wire             psel,
    input  wire             penable,
    input  wire             pwrite,
    input  wire  [2:0]      paddr,
    input  wire  [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [4:0]             feat_len_reg, feat_len_next;
    logic                   q_valid;
    sdba_pkg::qent_t        q_ent;
    sdba_pkg::back_status_t status;

    assign pready = 1'b1;

    always_comb
    begin
        feat_len_next = feat_len_reg;
        if (psel && penable && pwrite && (paddr[2] == sdba_pkg::CFG_FEAT_LEN))
        begin
            feat_len_next = pwdata[4:0];
        end
        prdata = (paddr[2] == sdba_pkg::CFG_FEAT_LEN) ? {27'd0, feat_len_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feat_len_reg <= sdba_pkg::FEAT_LEN_RESET;
        end
        else
        begin
            feat_len_reg <= feat_len_next;
        end
    end

    sdba_front #(
        .ROWS         (ROWS),
        .COLS         (COLS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .status    (status),
        .q_valid   (q_valid),
        .q_ent     (q_ent)
    );

    sdba_back #(
        .ROWS         (ROWS),
        .COLS         (COLS),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ent     (q_ent),
        .status    (status),
        .feat_len  (feat_len_reg),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- rtl/core/sdba_checker.sv -----
// port-level checker for the gradient accumulator, bound to the top level
`default_nettype none

`include "sddmm_backward_accumulate_assert.svh"

module sdba_checker (
    input wire            clk,
    input wire            rst_n,
    input wire            cmd_valid,
    input wire            cmd_stall,
    input wire            rsp_valid,
    input wire            rsp_stall,
    input sdba_pkg::rsp_t rsp,
    input wire            pready
);

    // the clearing sweep holds off commands right after reset
    `SDBA_ASSERT_IMPLY(a_init_stall, !$past(rst_n), cmd_stall)
    // a stalled result beat stays put
    `SDBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `SDBA_ASSERT_IMPLY(a_pready, cmd_valid || !cmd_valid, pready)

endmodule

bind sddmm_backward_accumulate sdba_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .pready    (pready)
);

`default_nettype wire

// ----- tb/tb_sddmm_backward_accumulate.sv -----
// self-checking testbench for the sparse-dense backward gradient accumulator
`default_nettype none

module tb_sddmm_backward_accumulate;

    localparam int NROWS     = 64;
    localparam int NCOLS     = 64;
    localparam int NFEAT     = 16;
    localparam int SPAN      = 8;
    localparam int SETTLE    = 4;
    localparam int CYCLE_CAP = 600000;
    localparam logic [2:0] FUNC_SPARE6 = 3'd6;
    localparam logic [2:0] FUNC_SPARE7 = 3'd7;
    localparam logic [2:0] ADDR_FEAT_LEN = {sdba_pkg::CFG_FEAT_LEN, 2'b00};
    localparam logic [2:0] ADDR_UNUSED   = 3'd4;

    logic           clk;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_stall;
    sdba_pkg::cmd_t cmd;
    logic           rsp_valid;
    logic           rsp_stall;
    sdba_pkg::rsp_t rsp;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    // predictor state
    logic signed [31:0] d1_model [NROWS][NFEAT];
    logic signed [31:0] d2_model [NCOLS][NFEAT];
    logic signed [31:0] g1_model [NROWS][NFEAT];
    logic signed [31:0] g2_model [NCOLS][NFEAT];
    bit                 d1_set [NROWS][NFEAT];
    bit                 d2_set [NCOLS][NFEAT];
    bit                 sat_model;
    logic [4:0]         feat_len_model;

    sdba_pkg::rsp_t grad_reads_due[$];
    int   errors;
    int   cycles;
    bit   jitter_on;

    sddmm_backward_accumulate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall, random while jitter is on
    always @(negedge clk)
        rsp_stall <= jitter_on && ($urandom_range(0, 99) < 12);

    function automatic logic signed [31:0] mac_sat(logic signed [31:0] acc,
                                                   logic signed [31:0] g,
                                                   logic signed [31:0] f);
        longint prod;
        longint sum;
        prod = (longint'(g) * longint'(f)) >>> 16;
        sum  = longint'(acc) + prod;
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
            sat_model = 1'b1;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648;
            sat_model = 1'b1;
        end
        return sum[31:0];
    endfunction

    function automatic void clear_grads();
        foreach (g1_model[r, f]) g1_model[r][f] = '0;
        foreach (g2_model[r, f]) g2_model[r][f] = '0;
        sat_model = 1'b0;
    endfunction

    function automatic int active_feats();
        return (feat_len_model > NFEAT) ? NFEAT : int'(feat_len_model);
    endfunction

    // expected effect of one accepted beat
    function automatic void predict_grads(sdba_pkg::cmd_t it);
        logic signed [31:0] f1;
        logic signed [31:0] f2;
        case (it.func)
            sdba_pkg::FUNC_LOAD1:  d1_model[it.row][it.feature] = it.value;
            sdba_pkg::FUNC_LOAD2:  d2_model[it.col][it.feature] = it.value;
            sdba_pkg::FUNC_UPDATE:
                for (int l = 0; l < active_feats(); l++)
                begin
                    f1 = d1_model[it.row][l];
                    f2 = d2_model[it.col][l];
                    g1_model[it.row][l] = mac_sat(g1_model[it.row][l], it.value, f2);
                    g2_model[it.col][l] = mac_sat(g2_model[it.col][l], it.value, f1);
                end
            sdba_pkg::FUNC_READ1:
                grad_reads_due.push_back('{g1_model[it.row][it.feature], sat_model});
            sdba_pkg::FUNC_READ2:
                grad_reads_due.push_back('{g2_model[it.col][it.feature], sat_model});
            sdba_pkg::FUNC_CLEAR:  clear_grads();
            default:               ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (grad_reads_due.size() == 0)
            begin
                $display("%0t: unexpected result beat grad_value=%h saturated=%b",
                         $time, rsp.grad_value, rsp.saturated);
                errors++;
            end
            else
            begin
                if (rsp.grad_value !== grad_reads_due[0].grad_value)
                begin
                    $display("%0t: grad_value expected %h actual %h", $time,
                             grad_reads_due[0].grad_value, rsp.grad_value);
                    errors++;
                end
                if (rsp.saturated !== grad_reads_due[0].saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             grad_reads_due[0].saturated, rsp.saturated);
                    errors++;
                end
                void'(grad_reads_due.pop_front());
            end
        end
    end

    function automatic sdba_pkg::cmd_t make_cmd(logic [2:0] func, int r, int c, int f,
                                                logic signed [31:0] v);
        sdba_pkg::cmd_t it;
        it.func    = func;
        it.row     = r[5:0];
        it.col     = c[5:0];
        it.feature = f[3:0];
        it.value   = v;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $signed($urandom_range(0, 32'h3fff)) - 32'sh2000;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(sdba_pkg::cmd_t it);
        if (jitter_on && $urandom_range(0, 99) < 12)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= it;
        do
            @(posedge clk);
        while (cmd_stall);
        predict_grads(it);
        if (it.func == sdba_pkg::FUNC_LOAD1) d1_set[it.row][it.feature] = 1'b1;
        if (it.func == sdba_pkg::FUNC_LOAD2) d2_set[it.col][it.feature] = 1'b1;
        @(negedge clk);
    endtask

    // loads any factor entry the update would read that is still unwritten, then sends the update
    task automatic send_update(int r, int c, logic signed [31:0] g);
        for (int l = 0; l < active_feats(); l++)
        begin
            if (!d1_set[r][l])
                send_beat(make_cmd(sdba_pkg::FUNC_LOAD1, r, $urandom_range(0, 63), l,
                                   rand_value()));
            if (!d2_set[c][l])
                send_beat(make_cmd(sdba_pkg::FUNC_LOAD2, $urandom_range(0, 63), c, l,
                                   rand_value()));
        end
        send_beat(make_cmd(sdba_pkg::FUNC_UPDATE, r, c, $urandom_range(0, 15), g));
    endtask

    // a read beat runs after everything before it, so its result marks the block idle
    task automatic wait_idle();
        send_beat(make_cmd(sdba_pkg::FUNC_READ1, 0, 0, 0, 0));
        cmd_valid <= 1'b0;
        while (grad_reads_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_FEAT_LEN)
            feat_len_model = data[4:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // waits for the block to go idle, then rewrites feat_len
    task automatic set_feat_len(logic [4:0] len);
        wait_idle();
        apb_write(ADDR_FEAT_LEN, {$urandom} & ~32'h1f | len);
    endtask

    task automatic test_directed();
        set_feat_len(5'd2);
        apb_write(ADDR_UNUSED, 32'h0000_0001);
        send_beat(make_cmd(sdba_pkg::FUNC_LOAD1, 5, 0, 0, 32'sh7fffffff));
        send_beat(make_cmd(sdba_pkg::FUNC_LOAD1, 5, 0, 1, 32'sh80000000));
        send_beat(make_cmd(sdba_pkg::FUNC_LOAD2, 0, 63, 0, 32'sh7fffffff));
        send_beat(make_cmd(sdba_pkg::FUNC_LOAD2, 0, 63, 1, 32'sh00010000));
        send_beat(make_cmd(sdba_pkg::FUNC_READ1, 0, 0, 15, 0));
        send_update(5, 63, 32'sh00010000);
        send_beat(make_cmd(sdba_pkg::FUNC_READ1, 5, 0, 0, 0));
        send_beat(make_cmd(sdba_pkg::FUNC_READ2, 0, 63, 1, 0));
        // large gradient pushes both accumulators to the clamps
        send_update(5, 63, 32'sh7fffffff);
        send_update(5, 63, 32'sh80000000);
        send_beat(make_cmd(sdba_pkg::FUNC_READ1, 5, 0, 0, 0));
        send_beat(make_cmd(sdba_pkg::FUNC_READ1, 5, 0, 1, 0));
        send_beat(make_cmd(sdba_pkg::FUNC_READ2, 0, 63, 0, 0));
        send_beat(make_cmd(sdba_pkg::FUNC_READ2, 63, 63, 15, 32'shffffffff));
        send_beat(make_cmd(FUNC_SPARE6, 63, 63, 15, 32'shffffffff));
        send_beat(make_cmd(FUNC_SPARE7, 0, 0, 0, 0));
        send_beat(make_cmd(sdba_pkg::FUNC_CLEAR, 0, 0, 0, 0));
        send_beat(make_cmd(sdba_pkg::FUNC_READ1, 5, 0, 1, 0));
        send_beat(make_cmd(sdba_pkg::FUNC_READ2, 0, 63, 0, 0));
        send_update(5, 63, 32'shffffffff);
        send_beat(make_cmd(sdba_pkg::FUNC_READ1, 5, 0, 1, 0));
    endtask

    // updates and reads stay in a small window so factor fills stay few
    task automatic test_random(int count);
        int pick;
        int done;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send_update($urandom_range(0, SPAN - 1), $urandom_range(0, SPAN - 1),
                            rand_value());
            else if (pick < 50)
                send_beat(make_cmd($urandom_range(0, 1) ? sdba_pkg::FUNC_LOAD2
                                                        : sdba_pkg::FUNC_LOAD1,
                                   $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 15), rand_value()));
            else if (pick < 97)
                send_beat(make_cmd($urandom_range(0, 1) ? sdba_pkg::FUNC_READ1
                                                        : sdba_pkg::FUNC_READ2,
                                   $urandom_range(0, SPAN - 1), $urandom_range(0, SPAN - 1),
                                   $urandom_range(0, 15), $urandom));
            else if (pick < 98)
                send_beat(make_cmd(sdba_pkg::FUNC_CLEAR, $urandom_range(0, 63),
                                   $urandom_range(0, 63), $urandom_range(0, 15),
                                   $urandom));
            else
            begin
                send_beat(make_cmd($urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7,
                                   $urandom_range(0, 63), $urandom_range(0, 63),
                                   $urandom_range(0, 15), $urandom));
                continue;
            end
            done++;
        end
    endtask

    task automatic test_feat_len_sweep();
        set_feat_len(5'd16);
        test_random(150);
        set_feat_len(5'd1);
        test_random(60);
        // zero features: updates leave the gradients alone
        set_feat_len(5'd0);
        test_random(40);
        // above the maximum acts as the maximum
        set_feat_len(5'd31);
        test_random(60);
    endtask

    task automatic test_no_jitter();
        set_feat_len(5'd7);
        jitter_on = 1'b0;
        test_random(140);
        jitter_on = 1'b1;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        rsp_stall = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        errors    = 0;
        cycles    = 0;
        jitter_on = 1'b1;
        feat_len_model = sdba_pkg::FEAT_LEN_RESET;
        clear_grads();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_feat_len_sweep();
        test_no_jitter();

        wait_idle();
        if (errors == 0 && grad_reads_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sdba_pkg.sv
rtl/core/sdba_front.sv
rtl/core/sdba_back.sv
rtl/core/sddmm_backward_accumulate.sv
rtl/core/sdba_checker.sv
tb/tb_sddmm_backward_accumulate.sv
